FILE: rtl/kuznyechik_ctr_cipher_macros.svh
// Assertion macros used by the checker file kz_checker.sv.
`ifndef KUZNYECHIK_CTR_CIPHER_MACROS_SVH
`define KUZNYECHIK_CTR_CIPHER_MACROS_SVH
// Implication checked every cycle out of reset.
`define KZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define KZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/kz_pkg.sv
// ----------------------------------------------------------------------------
// kz_pkg
// Constants, S-box and GF(2^8) helpers for the Kuznyechik cipher.
// ----------------------------------------------------------------------------
package kz_pkg;
  localparam int unsigned BlkW   = 128;
  localparam int unsigned WordW  = 64;
  localparam int unsigned RkDepth = 20;
  localparam int unsigned RkAw   = 5;
  localparam int unsigned CfgAw  = 3;

  localparam logic [CfgAw-1:0] RegKey0 = 3'd0;
  localparam logic [CfgAw-1:0] RegKey1 = 3'd1;
  localparam logic [CfgAw-1:0] RegKey2 = 3'd2;
  localparam logic [CfgAw-1:0] RegKey3 = 3'd3;
  localparam logic [CfgAw-1:0] RegMode = 3'd4;
  localparam logic [CfgAw-1:0] RegIv   = 3'd5;

  localparam logic [7:0] Poly = 8'hC3;

  localparam logic [7:0] Sbox [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] LinCoef [16] = '{
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r ^= x;
      x = x[7] ? ({x[6:0], 1'b0} ^ Poly) : {x[6:0], 1'b0};
    end
    return r;
  endfunction

  // one step of the LFSR form of L
  function automatic logic [BlkW-1:0] r_step(input logic [BlkW-1:0] v);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) acc ^= gf_mul(v[8*i +: 8], LinCoef[i]);
    return {acc, v[BlkW-1:8]};
  endfunction

  function automatic logic [BlkW-1:0] sub_bytes(input logic [BlkW-1:0] v);
    logic [BlkW-1:0] o;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = Sbox[v[8*i +: 8]];
    return o;
  endfunction
endpackage

FILE: rtl/kz_ram.sv
// ----------------------------------------------------------------------------
// kz_ram
// Generic simple dual-port synchronous RAM (separate write and read addresses) with registered read.
// ----------------------------------------------------------------------------
module kz_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/kz_lin.sv
// ----------------------------------------------------------------------------
// kz_lin
// Linear layer L as sixteen LFSR steps, four per cycle, with start/done.
// ----------------------------------------------------------------------------
module kz_lin (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [kz_pkg::BlkW-1:0] data_i,
  output logic                    done_o,
  output logic [kz_pkg::BlkW-1:0] data_o
);
  logic [kz_pkg::BlkW-1:0] v_q;
  logic [1:0] cnt_q;
  logic busy_q;
  logic [kz_pkg::BlkW-1:0] v4;

  always_comb begin
    v4 = kz_pkg::r_step(kz_pkg::r_step(kz_pkg::r_step(kz_pkg::r_step(
         start_i ? data_i : v_q))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i || busy_q) v_q <= v4;
  end

  assign data_o = v_q;
endmodule

FILE: rtl/kuznyechik_ctr_cipher.sv
// ----------------------------------------------------------------------------
// kuznyechik_ctr_cipher
// Kuznyechik block cipher, ECB or 64-bit counter mode.
// ----------------------------------------------------------------------------
// Usage:
//   Config port: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
//   Registers: key words 0..3, mode, iv. A key write forces re-expansion.
//   s_axis: tdata = {first_block, data_high, data_low}, one transaction per
//   block. m_axis: tdata = {out_high, out_low}.
//   One block at a time. Each round reads its key from the round key RAM
//   (StRdLo, StRdHi, StRdWait), then starts the linear layer (StLin) and
//   waits in StLinWait while it runs four LFSR steps a cycle. After nine
//   such rounds the last round key (and in counter mode the data) is added
//   and the result is registered; no new block is taken meanwhile. The first
//   block after a key change first runs the 32-step schedule, with 5 key
//   stores of four round key words each.
//   Reset clears state, counter and key-valid flag; round key RAM is not
//   cleared. The result waits in the output register while m_axis_tready is
//   low; the next block is taken only after it is delivered.
// ----------------------------------------------------------------------------
module kuznyechik_ctr_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kz_pkg::CfgAw-1:0]    cfg_idx_i,
  input  logic [kz_pkg::WordW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // data_low, data_high, first_block
  input  logic [135:0]                s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_low, out_high
  output logic [127:0]                m_axis_tdata
);
  typedef enum logic [3:0] {
    StIdle, StKsLin, StKsWait, StKsStore, StRdLo, StRdHi, StRdWait,
    StLin, StLinWait, StOut
  } state_e;

  state_e state_q;
  logic [kz_pkg::WordW-1:0] key_q [4];
  logic mode_q, ready_q;
  logic [kz_pkg::WordW-1:0] iv_q, ctr_q;
  logic [kz_pkg::BlkW-1:0] v_q, data_q, a0_q, a1_q, res_q;
  logic [5:0] step_q;
  logic [3:0] rnd_q;
  logic [2:0] st_q;
  logic [kz_pkg::WordW-1:0] klo_q;
  logic ks_q;

  logic ram_we;
  logic [kz_pkg::RkAw-1:0] ram_waddr, ram_raddr;
  logic [kz_pkg::WordW-1:0] ram_wdata, ram_rdata;

  logic lin_start, lin_done;
  logic [kz_pkg::BlkW-1:0] lin_in, lin_out;

  kz_ram #(.Width(kz_pkg::WordW), .Depth(kz_pkg::RkDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  kz_lin u_lin (
    .clk_i, .rst_ni, .start_i(lin_start), .data_i(lin_in),
    .done_o(lin_done), .data_o(lin_out)
  );

  logic [5:0] step_nx;
  logic [kz_pkg::BlkW-1:0] cvec, rk;
  assign step_nx = step_q + 6'd1;
  always_comb begin
    cvec = '0;
    cvec[5:0] = step_nx;
    rk = {ram_rdata, klo_q};
  end

  // key schedule write pattern: st_q 0..3 writes a1 lo/hi, a0 lo/hi;
  // step_q is 63 for the initial pair
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (state_q == StKsStore) begin
      ram_we = 1'b1;
      ram_waddr = kz_pkg::RkAw'({step_nx[5:3], st_q[1:0]});
      unique case (st_q[1:0])
        2'd0: ram_wdata = a1_q[63:0];
        2'd1: ram_wdata = a1_q[127:64];
        2'd2: ram_wdata = a0_q[63:0];
        default: ram_wdata = a0_q[127:64];
      endcase
    end
  end
  assign ram_raddr = (state_q == StRdLo) ? kz_pkg::RkAw'({rnd_q, 1'b0})
                                         : kz_pkg::RkAw'({rnd_q, 1'b1});

  always_comb begin
    lin_start = 1'b0;
    lin_in = kz_pkg::sub_bytes(v_q ^ rk);
    if (state_q == StIdle && s_axis_tvalid && s_axis_tready && ready_q) begin
      lin_start = 1'b0;
    end
    if (state_q == StKsLin) begin
      lin_start = 1'b1;
      lin_in = ks_q ? kz_pkg::sub_bytes(a1_q ^ lin_out) : cvec;
    end else if (state_q == StLin) begin
      lin_start = 1'b1;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b0;
      mode_q  <= 1'b0;
      iv_q    <= '0;
      ctr_q   <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      step_q <= '0;
      rnd_q  <= '0;
      st_q   <= '0;
      ks_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kz_pkg::RegKey0, kz_pkg::RegKey1, kz_pkg::RegKey2, kz_pkg::RegKey3: begin
            key_q[cfg_idx_i[1:0]] <= cfg_data_i;
            ready_q <= 1'b0;
          end
          kz_pkg::RegMode: mode_q <= cfg_data_i[0];
          kz_pkg::RegIv:   iv_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            data_q <= s_axis_tdata[127:0];
            rnd_q <= '0;
            if (mode_q) begin
              if (s_axis_tdata[128]) begin
                ctr_q <= iv_q;
                v_q <= {64'd0, iv_q};
              end else begin
                ctr_q <= ctr_q + 64'd1;
                v_q <= {64'd0, ctr_q + 64'd1};
              end
            end else begin
              v_q <= s_axis_tdata[127:0];
            end
            if (ready_q) begin
              state_q <= StRdLo;
            end else begin
              a1_q <= {key_q[3], key_q[2]};
              a0_q <= {key_q[1], key_q[0]};
              step_q <= 6'd63;
              st_q <= '0;
              state_q <= StKsStore;
            end
          end
        end
        StKsLin: begin
          state_q <= StKsWait;
        end
        StKsWait: begin
          if (lin_done) begin
            if (ks_q) begin
              a1_q <= lin_out ^ a0_q;
              a0_q <= a1_q;
              ks_q <= 1'b0;
              if (step_q[2:0] == 3'd7) begin
                st_q <= '0;
                state_q <= StKsStore;
              end else begin
                step_q <= step_q + 6'd1;
                state_q <= StKsLin;
              end
            end else begin
              ks_q <= 1'b1;
              state_q <= StKsLin;
            end
          end
        end
        StKsStore: begin
          st_q <= st_q + 3'd1;
          if (st_q == 3'd3) begin
            if (step_q == 6'd31) begin
              ready_q <= 1'b1;
              state_q <= StRdLo;
            end else begin
              step_q <= step_q + 6'd1;
              state_q <= StKsLin;
            end
          end
        end
        StRdLo: state_q <= StRdHi;
        StRdHi: begin
          klo_q <= ram_rdata;
          state_q <= StRdWait;
        end
        StRdWait: begin
          if (rnd_q == 4'd9) begin
            res_q <= (v_q ^ rk) ^ (mode_q ? data_q : '0);
            state_q <= StOut;
          end else begin
            state_q <= StLin;
          end
        end
        StLin: state_q <= StLinWait;
        StLinWait: begin
          if (lin_done) begin
            v_q <= lin_out;
            rnd_q <= rnd_q + 4'd1;
            state_q <= StRdLo;
          end
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: rtl/kz_checker.sv
// ----------------------------------------------------------------------------
// kz_checker
// Port-level checks for kuznyechik_ctr_cipher.
// ----------------------------------------------------------------------------
`include "kuznyechik_ctr_cipher_macros.svh"
module kz_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  `KZ_ASSERT_IMP(a_excl, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `KZ_ASSERT_NXT(a_no_fast, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
  `KZ_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata))
  `KZ_ASSERT_NXT(a_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

bind kuznyechik_ctr_cipher kz_checker u_kz_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata
);
